/* src/ut_pkg.sv */
// ============================================================================
// ut_pkg - shared types and helpers for the Unicode transcoder
// Scheme codes, register indexes, decoded-operation bundle and the
// per-byte target encoder used by the back end.
// ============================================================================
package ut_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int OP_SLOTS       = 5;

    // Scheme codes
    localparam logic [2:0] SCH_UTF8  = 3'd0;
    localparam logic [2:0] SCH_U16LE = 3'd1;
    localparam logic [2:0] SCH_U16BE = 3'd2;
    localparam logic [2:0] SCH_U32LE = 3'd3;
    localparam logic [2:0] SCH_U32BE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_SRC  = 2'd0;
    localparam logic [1:0] REG_TGT  = 2'd1;
    localparam logic [1:0] REG_REPL = 2'd2;
    localparam logic [1:0] REG_BOM  = 2'd3;

    localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
    localparam logic [20:0] CP_BOM     = 21'h00FEFF;

    typedef enum logic [1:0] {
        OP_SCALAR,
        OP_FAIL,
        OP_DONE
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [20:0] value;
        logic [31:0] offset;
    } op_t;

    typedef struct packed {
        op_t [OP_SLOTS-1:0] ops;
        logic [2:0]         last_idx;
    } bundle_t;

    typedef struct packed {
        logic [2:0] source_scheme;
        logic [2:0] target_scheme;
        logic       replace_mode;
        logic       emit_bom;
    } cfg_t;

    // Sequence length of a UTF-8 lead byte, 0 when not a valid lead
    function automatic logic [2:0] utf8_need(input logic [7:0] lead);
        logic [2:0] r;
        r = 3'd0;
        if (lead >= 8'hC2 && lead <= 8'hDF)
            r = 3'd2;
        else if (lead >= 8'hE0 && lead <= 8'hEF)
            r = 3'd3;
        else if (lead >= 8'hF0 && lead <= 8'hF4)
            r = 3'd4;
        return r;
    endfunction

    // Continuation byte range check, narrowed at the second position
    function automatic logic utf8_cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                          input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 2'd1) begin
            if (lead == 8'hE0)
                lo = 8'hA0;
            else if (lead == 8'hED)
                hi = 8'h9F;
            else if (lead == 8'hF0)
                lo = 8'h90;
            else if (lead == 8'hF4)
                hi = 8'h8F;
        end
        return (b >= lo) && (b <= hi);
    endfunction

    // Index of the last output byte of a scalar in the target scheme
    function automatic logic [1:0] enc_last(input logic [20:0] s, input logic [2:0] tgt);
        logic [1:0] r;
        r = 2'd0;
        unique case (tgt)
            SCH_UTF8:
            begin
                if (s < 21'h80)
                    r = 2'd0;
                else if (s < 21'h800)
                    r = 2'd1;
                else if (s < 21'h10000)
                    r = 2'd2;
                else
                    r = 2'd3;
            end
            SCH_U16LE, SCH_U16BE:
                r = (s < 21'h10000) ? 2'd1 : 2'd3;
            SCH_U32LE, SCH_U32BE:
                r = 2'd3;
            default:
                r = 2'd0;
        endcase
        return r;
    endfunction

    // One output byte of a scalar in the target scheme
    function automatic logic [7:0] enc_byte(input logic [20:0] s, input logic [2:0] tgt,
                                            input logic [1:0] idx);
        logic [19:0] v;
        logic [15:0] unit;
        logic [31:0] w;
        logic [7:0]  r;
        v    = 20'(s - 21'h010000);
        w    = {11'd0, s};
        unit = (s < 21'h10000) ? s[15:0] :
               (idx[1] ? {6'b110111, v[9:0]} : {6'b110110, v[19:10]});
        r    = 8'h00;
        unique case (tgt)
            SCH_UTF8:
            begin
                if (s < 21'h80)
                    r = {1'b0, s[6:0]};
                else if (s < 21'h800)
                    r = (idx == 2'd0) ? {3'b110, s[10:6]} : {2'b10, s[5:0]};
                else if (s < 21'h10000) begin
                    if (idx == 2'd0)
                        r = {4'b1110, s[15:12]};
                    else if (idx == 2'd1)
                        r = {2'b10, s[11:6]};
                    else
                        r = {2'b10, s[5:0]};
                end else begin
                    if (idx == 2'd0)
                        r = {5'b11110, s[20:18]};
                    else if (idx == 2'd1)
                        r = {2'b10, s[17:12]};
                    else if (idx == 2'd2)
                        r = {2'b10, s[11:6]};
                    else
                        r = {2'b10, s[5:0]};
                end
            end
            SCH_U16LE:
                r = idx[0] ? unit[15:8] : unit[7:0];
            SCH_U16BE:
                r = idx[0] ? unit[7:0] : unit[15:8];
            SCH_U32LE:
                r = 8'(w >> {idx, 3'b000});
            SCH_U32BE:
                r = 8'(w >> {~idx, 3'b000});
            default:
                r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* src/ut_front.sv */
// ============================================================================
// ut_front - source decoder
// Accepts source bytes, decodes UTF-8/16/32 and turns each transaction
// into a bundle of scalar, failure and end operations for the back end.
// ============================================================================
module ut_front
    import ut_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    src_clear,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic [7:0] src_byte,
    input  logic    src_last,
    output logic    push_valid,
    input  logic    push_ready,
    output bundle_t push_data
);

    logic [7:0]            pend_reg [3];
    logic [7:0]            pend_next [3];
    logic [1:0]            pcnt_reg, pcnt_next;
    logic [15:0]           hs_reg, hs_next;
    logic                  held_reg, held_next;
    logic [COUNT_BITS-1:0] soff_reg, soff_next;
    logic                  bom_done_reg, bom_done_next;
    logic                  stopped_reg, stopped_next;

    logic                  accept;
    op_t [7:0]             ops_v;
    logic [2:0]            n;

    function automatic logic [31:0] off_of(input logic [COUNT_BITS-1:0] nx,
                                           input logic [2:0] k);
        return (nx > COUNT_BITS'(k)) ? 32'(nx - COUNT_BITS'(k)) : 32'd0;
    endfunction

    function automatic op_t bad_op(input logic repl, input logic [31:0] off);
        op_t o;
        o.kind   = repl ? OP_SCALAR : OP_FAIL;
        o.value  = CP_REPLACE;
        o.offset = repl ? 32'd0 : off;
        return o;
    endfunction

    function automatic op_t scalar_op(input logic [20:0] s);
        op_t o;
        o.kind   = OP_SCALAR;
        o.value  = s;
        o.offset = 32'd0;
        return o;
    endfunction

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && !stopped_reg && (n != 3'd0);

    assign push_data.ops      = ops_v[OP_SLOTS-1:0];
    assign push_data.last_idx = n - 3'd1;

    // Decode one source byte into operations and the next decoder state
    always_comb
    begin
        logic                  halt;
        logic                  fresh;
        logic [1:0]            pc;
        logic [1:0]            cnt;
        logic [2:0]            need;
        logic [COUNT_BITS-1:0] nx;
        logic [20:0]           s;
        logic [15:0]           u;
        logic [31:0]           v;
        logic                  done;
        logic                  be;

        ops_v         = '0;
        n             = 3'd0;
        halt          = 1'b0;
        fresh         = 1'b0;
        pc            = pcnt_reg;
        cnt           = pcnt_reg;
        need          = 3'd0;
        s             = 21'd0;
        u             = 16'd0;
        v             = 32'd0;
        done          = 1'b0;
        be            = 1'b0;
        pend_next     = pend_reg;
        hs_next       = hs_reg;
        held_next     = held_reg;
        bom_done_next = bom_done_reg;
        nx            = (soff_reg == '1) ? soff_reg : soff_reg + 1'b1;
        soff_next     = soff_reg;

        if (cfg.source_scheme > SCH_U32BE || cfg.target_scheme > SCH_U32BE) begin
            ops_v[0] = '{kind: OP_FAIL, value: 21'd0, offset: 32'd0};
            n        = 3'd1;
            halt     = 1'b1;
        end else begin
            // Byte order mark ahead of the first output
            if (!bom_done_reg && cfg.emit_bom) begin
                ops_v[n] = scalar_op(CP_BOM);
                n        = n + 3'd1;
            end
            bom_done_next = 1'b1;
            soff_next     = nx;

            if (cfg.source_scheme == SCH_UTF8) begin
                if (pc != 2'd0) begin
                    need = utf8_need(pend_reg[0]);
                    if (need != 3'd0 && {1'b0, cnt} < need &&
                        utf8_cont_ok(pend_reg[0], cnt, src_byte)) begin
                        if (3'({1'b0, cnt} + 3'd1) == need) begin
                            if (need == 3'd2)
                                s = {10'd0, pend_reg[0][4:0], src_byte[5:0]};
                            else if (need == 3'd3)
                                s = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0],
                                     src_byte[5:0]};
                            else
                                s = {pend_reg[0][2:0], pend_reg[1][5:0],
                                     pend_reg[2][5:0], src_byte[5:0]};
                            pc       = 2'd0;
                            ops_v[n] = scalar_op(s);
                            n        = n + 3'd1;
                        end else begin
                            pend_next[cnt] = src_byte;
                            pc             = cnt + 2'd1;
                        end
                    end else begin
                        pc       = 2'd0;
                        ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, 3'd1 + {1'b0, cnt}));
                        n        = n + 3'd1;
                        halt     = !cfg.replace_mode;
                        fresh    = !halt;
                    end
                end else begin
                    fresh = 1'b1;
                end

                // Take the byte as the start of a new sequence
                if (fresh) begin
                    if (src_byte < 8'h80) begin
                        ops_v[n] = scalar_op({13'd0, src_byte});
                        n        = n + 3'd1;
                    end else if (utf8_need(src_byte) != 3'd0) begin
                        pend_next[0] = src_byte;
                        pc           = 2'd1;
                    end else begin
                        ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, 3'd1));
                        n        = n + 3'd1;
                        halt     = !cfg.replace_mode;
                    end
                end

                // Truncated tail
                if (src_last && pc != 2'd0 && !halt) begin
                    ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, {1'b0, pc}));
                    n        = n + 3'd1;
                    halt     = !cfg.replace_mode;
                    pc       = 2'd0;
                end
            end else if (cfg.source_scheme <= SCH_U16BE) begin
                be = (cfg.source_scheme == SCH_U16BE);
                if (pc == 2'd0) begin
                    pend_next[0] = src_byte;
                    pc           = 2'd1;
                end else begin
                    u  = be ? {pend_reg[0], src_byte} : {src_byte, pend_reg[0]};
                    pc = 2'd0;
                    if (held_reg) begin
                        held_next = 1'b0;
                        if (u >= 16'hDC00 && u <= 16'hDFFF) begin
                            ops_v[n] = scalar_op(21'h010000 + {1'b0, hs_reg[9:0], u[9:0]});
                            n        = n + 3'd1;
                            done     = 1'b1;
                        end else begin
                            ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, 3'd4));
                            n        = n + 3'd1;
                            halt     = !cfg.replace_mode;
                        end
                    end
                    if (!done && !halt) begin
                        if (u >= 16'hD800 && u <= 16'hDBFF) begin
                            hs_next   = u;
                            held_next = 1'b1;
                        end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
                            ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, 3'd2));
                            n        = n + 3'd1;
                            halt     = !cfg.replace_mode;
                        end else begin
                            ops_v[n] = scalar_op({5'd0, u});
                            n        = n + 3'd1;
                        end
                    end
                end

                // Truncated tail: held surrogate first, then a lone byte
                if (src_last && !halt) begin
                    if (held_next) begin
                        held_next = 1'b0;
                        ops_v[n]  = bad_op(cfg.replace_mode,
                                           off_of(nx, (pc != 2'd0) ? 3'd3 : 3'd2));
                        n         = n + 3'd1;
                        halt      = !cfg.replace_mode;
                    end
                    if (!halt && pc != 2'd0) begin
                        pc       = 2'd0;
                        ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, 3'd1));
                        n        = n + 3'd1;
                        halt     = !cfg.replace_mode;
                    end
                end
            end else begin
                if (pc != 2'd3) begin
                    pend_next[pc] = src_byte;
                    pc            = pc + 2'd1;
                end else begin
                    if (cfg.source_scheme == SCH_U32BE)
                        v = {pend_reg[0], pend_reg[1], pend_reg[2], src_byte};
                    else
                        v = {src_byte, pend_reg[2], pend_reg[1], pend_reg[0]};
                    pc = 2'd0;
                    if (v <= 32'h10FFFF && !(v >= 32'hD800 && v <= 32'hDFFF)) begin
                        ops_v[n] = scalar_op(v[20:0]);
                        n        = n + 3'd1;
                    end else begin
                        ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, 3'd4));
                        n        = n + 3'd1;
                        halt     = !cfg.replace_mode;
                    end
                end
                if (src_last && pc != 2'd0 && !halt) begin
                    ops_v[n] = bad_op(cfg.replace_mode, off_of(nx, {1'b0, pc}));
                    n        = n + 3'd1;
                    halt     = !cfg.replace_mode;
                    pc       = 2'd0;
                end
            end

            // Normal end of the stream
            if (!halt && src_last) begin
                ops_v[n] = '{kind: OP_DONE, value: 21'd0, offset: 32'd0};
                n        = n + 3'd1;
                halt     = 1'b1;
            end
        end

        pcnt_next    = pc;
        stopped_next = halt;
    end

    // Hold decoder state; advance on each live transaction, drop pending bytes on a source write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pcnt_reg     <= 2'd0;
            held_reg     <= 1'b0;
            hs_reg       <= 16'd0;
            soff_reg     <= '0;
            bom_done_reg <= 1'b0;
            stopped_reg  <= 1'b0;
            pend_reg     <= '{default: 8'd0};
        end else begin
            if (src_clear) begin
                pcnt_reg <= 2'd0;
                held_reg <= 1'b0;
            end else if (accept && !stopped_reg) begin
                pend_reg     <= pend_next;
                pcnt_reg     <= pcnt_next;
                hs_reg       <= hs_next;
                held_reg     <= held_next;
                soff_reg     <= soff_next;
                bom_done_reg <= bom_done_next;
                stopped_reg  <= stopped_next;
            end
        end
    end

endmodule

/* src/ut_queue.sv */
// ============================================================================
// ut_queue - two-entry bundle queue
// Decouples the decoder from the encoder so each side stalls on its own.
// ============================================================================
module ut_queue
    import ut_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  bundle_t    push_data,
    output logic       pop_valid,
    input  logic       pop,
    output bundle_t    pop_data,
    output logic [1:0] level
);

    bundle_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign level      = cnt_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

/* src/ut_back.sv */
// ============================================================================
// ut_back - target encoder
// Walks the operations of each bundle and, while the output is not stalled,
// emits one result per cycle into the output register, counting written bytes.
// ============================================================================
module ut_back
    import ut_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  target_scheme,
    input  logic        q_valid,
    output logic        q_pop,
    input  bundle_t     q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        finished,
    output logic        conv_status,
    output logic [31:0] error_offset,
    output logic [31:0] written_count
);

    bundle_t               cur_reg;
    logic                  cur_valid_reg;
    logic [2:0]            idx_reg;
    logic [1:0]            bi_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_inc;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  byte_valid_reg;
    logic                  run_last_reg;
    logic                  finished_reg;
    logic                  status_reg;
    logic [31:0]           eoff_reg;
    logic [31:0]           written_reg;

    op_t                   op;
    logic                  advance;
    logic                  op_end;
    logic                  bundle_end;
    logic                  is_scalar;

    assign op         = cur_reg.ops[idx_reg];
    assign is_scalar  = (op.kind == OP_SCALAR);
    assign advance    = cur_valid_reg && (!out_valid_reg || out_ready);
    assign op_end     = !is_scalar || (bi_reg == enc_last(op.value, target_scheme));
    assign bundle_end = op_end && (idx_reg == cur_reg.last_idx);
    assign q_pop      = q_valid && (!cur_valid_reg || (advance && bundle_end));
    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // Load bundles and step through operations and bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            bi_reg        <= 2'd0;
            count_reg     <= '0;
        end else begin
            if (advance && is_scalar)
                count_reg <= count_inc;
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
                bi_reg        <= 2'd0;
            end else if (advance) begin
                if (bundle_end) begin
                    cur_valid_reg <= 1'b0;
                end else if (op_end) begin
                    idx_reg <= idx_reg + 3'd1;
                    bi_reg  <= 2'd0;
                end else begin
                    bi_reg <= bi_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance) begin
            run_last_reg <= bundle_end;
            unique case (op.kind)
                OP_SCALAR:
                begin
                    out_byte_reg   <= enc_byte(op.value, target_scheme, bi_reg);
                    byte_valid_reg <= 1'b1;
                    finished_reg   <= 1'b0;
                    status_reg     <= 1'b0;
                    eoff_reg       <= 32'd0;
                    written_reg    <= 32'(count_inc);
                end
                OP_FAIL:
                begin
                    out_byte_reg   <= 8'd0;
                    byte_valid_reg <= 1'b0;
                    finished_reg   <= 1'b1;
                    status_reg     <= 1'b1;
                    eoff_reg       <= op.offset;
                    written_reg    <= 32'(count_reg);
                end
                default:
                begin
                    out_byte_reg   <= 8'd0;
                    byte_valid_reg <= 1'b0;
                    finished_reg   <= 1'b1;
                    status_reg     <= 1'b0;
                    eoff_reg       <= 32'd0;
                    written_reg    <= 32'(count_reg);
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign run_last      = run_last_reg;
    assign finished      = finished_reg;
    assign conv_status   = status_reg;
    assign error_offset  = eoff_reg;
    assign written_count = written_reg;

endmodule

/* src/unicode_transcoder.sv */
// ============================================================================
// unicode_transcoder - streaming UTF-8/16/32 transcoder
// Decodes a source byte stream and re-encodes it in the target scheme.
// ============================================================================
// Usage:
//   Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data
//   (0 source scheme, 1 target scheme, 2 replace mode, 3 emit BOM). Write
//   only while no transaction is in flight. cfg_ready is always high.
//   Input: one source byte per transaction on in_valid/in_ready, src_last on
//   the final byte. Output: one result per transaction on out_valid/out_ready,
//   a data byte or the final status result; run_last marks the last result
//   caused by an input transaction.
//   Each input bundle passes through the queue, the encoder's current-bundle
//   register and the output register. Throughput: the encoder emits one
//   result per cycle while the receiver takes them; an input byte causes 0
//   to 9 results, typically 1 to 4. The decoder takes one byte per cycle
//   while its two-entry bundle queue has room; when the receiver stalls the
//   output register holds, the queue fills and in_ready drops. Reset clears
//   decoder state, config and counters but not stored data; no clearing pass.
// ============================================================================
module unicode_transcoder
    import ut_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  src_byte,
    input  logic        src_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        finished,
    output logic        conv_status,
    output logic [31:0] error_offset,
    output logic [31:0] written_count
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic       src_clear;
    logic       push_valid;
    logic       push_ready;
    bundle_t    push_data;
    logic       q_valid;
    logic       q_pop;
    bundle_t    q_data;
    logic [1:0] q_level;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign src_clear = cfg_wr && (cfg_index == REG_SRC);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_SRC:  cfg_reg.source_scheme <= cfg_data;
                REG_TGT:  cfg_reg.target_scheme <= cfg_data;
                REG_REPL: cfg_reg.replace_mode  <= cfg_data[0];
                REG_BOM:  cfg_reg.emit_bom      <= cfg_data[0];
                default:  cfg_reg               <= cfg_reg;
            endcase
        end
    end

    ut_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .src_clear  (src_clear),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .src_byte   (src_byte),
        .src_last   (src_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ut_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data),
        .level      (q_level)
    );

    ut_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_scheme (cfg_reg.target_scheme),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .run_last      (run_last),
        .finished      (finished),
        .conv_status   (conv_status),
        .error_offset  (error_offset),
        .written_count (written_count)
    );

`ifndef SYNTH
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_level != 2'd3)
        else $error("bundle queue level out of range");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> run_last)
        else $error("status result not last of its run");

    a_data_not_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !finished && !conv_status)
        else $error("data result carries status");

    a_ready_follows_queue: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (q_level != 2'd2))
        else $error("input ready disagrees with queue level");
`endif

endmodule
